>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge out of reset
`define CHD_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// cons must hold in the same cycle whenever ante holds
`define CHD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> src/chd_pkg.sv
// ----------------------------------------------------------------------------
// Chunked body decoder package
// Types, codes and helpers shared by the decoder and its channel interfaces.
// ----------------------------------------------------------------------------
package chd_pkg;

	localparam int unsigned MAX_BODY_BYTES_DEF  = 2 * 1024 * 1024;
	localparam int unsigned MAX_SIZE_DIGITS_DEF = 16;

	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_SEMI = 8'h3B;

	typedef enum logic [2:0] {
		PH_SIZE   = 3'd0,
		PH_DATA   = 3'd1,
		PH_BND_CR = 3'd2,
		PH_BND_LF = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_NO_LINE_END  = 3'd1,
		ST_BAD_LENGTH   = 3'd2,
		ST_TOO_LARGE    = 3'd3,
		ST_INCOMPLETE   = 3'd4,
		ST_BAD_BOUNDARY = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		PE_NONE       = 2'd0,
		PE_BAD_LENGTH = 2'd1,
		PE_TOO_LARGE  = 2'd2
	} pend_t;

	// bit 4 set: not a hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] v;
		if (b >= 8'h30 && b <= 8'h39) begin
			v = {1'b0, 4'(b - 8'h30)};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			v = {1'b0, 4'(b - 8'h57)};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			v = {1'b0, 4'(b - 8'h37)};
		end else begin
			v = 5'h10;
		end
		return v;
	endfunction

	function automatic status_t pend_status(input pend_t p);
		status_t s;
		unique case (p)
			PE_BAD_LENGTH: s = ST_BAD_LENGTH;
			PE_TOO_LARGE:  s = ST_TOO_LARGE;
			default:       s = ST_OK;
		endcase
		return s;
	endfunction

endpackage

>>> src/chd_in_if.sv
// ----------------------------------------------------------------------------
// Body byte channel
// Valid/ready channel carrying one raw body byte and its last-byte mark.
// ----------------------------------------------------------------------------
interface chd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_body;

	modport source (output valid, output in_byte, output end_of_body, input ready);
	modport sink   (input valid, input in_byte, input end_of_body, output ready);
endinterface

>>> src/chd_out_if.sv
// ----------------------------------------------------------------------------
// Decoded result channel
// Valid/ready channel carrying one payload byte or one body outcome.
// ----------------------------------------------------------------------------
interface chd_out_if;
	logic       valid;
	logic       ready;
	logic       byte_valid;
	logic [7:0] out_byte;
	logic       finished;
	logic [2:0] status;

	modport source (output valid, output byte_valid, output out_byte, output finished,
		output status, input ready);
	modport sink   (input valid, input byte_valid, input out_byte, input finished,
		input status, output ready);
endinterface

>>> src/http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// HTTP/1.1 chunked body decoder
// Streams a chunked body byte by byte and emits payload bytes and an outcome.
// ----------------------------------------------------------------------------
// The decoder takes one body byte per clock unless the output stalls, and
// returns one item per byte that has something to say: a payload byte, or the
// outcome of the body (finished with a status). Bytes of the size lines and
// chunk boundaries make no payload item. Each byte sits in the input
// register, where the whole parse step for it runs and the decoder state
// updates, and the item it causes lands in the output register; throughput is
// one byte per clock while the consumer keeps up. body.ready stays high while
// the output register drains, so a stalled consumer stops the input only once
// both registers are full. Payload bytes go out before the chunk is known good;
// on any non-zero status the consumer drops what it received for that body.
// After the outcome, bytes up to the marked last byte are swallowed, and the
// last byte re-arms for a new body.
`include "assert_macros.svh"

module http_chunked_body_decoder #(
	parameter int unsigned MAX_BODY_BYTES  = chd_pkg::MAX_BODY_BYTES_DEF,
	parameter int unsigned MAX_SIZE_DIGITS = chd_pkg::MAX_SIZE_DIGITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	chd_in_if.sink    body,
	chd_out_if.source decoded
);

	// counter widths: sizes and totals up to MAX_BODY_BYTES, digit count
	// saturating one above MAX_SIZE_DIGITS
	localparam int unsigned CNT_W = $clog2(MAX_BODY_BYTES + 1);
	localparam int unsigned DIG_W = $clog2(MAX_SIZE_DIGITS + 2);
	localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_BODY_BYTES);
	localparam logic [CNT_W:0]   MAX_SUM  = (CNT_W + 1)'(MAX_BODY_BYTES);
	localparam logic [CNT_W+3:0] MAX_NEXT = (CNT_W + 4)'(MAX_BODY_BYTES);
	localparam logic [DIG_W-1:0] DIG_SAT  = DIG_W'(MAX_SIZE_DIGITS + 1);
	localparam logic [DIG_W-1:0] DIG_LIM  = DIG_W'(MAX_SIZE_DIGITS);

	// input register
	logic       s1_valid_q;
	logic [7:0] s1_byte_s1;
	logic       s1_last_s1;

	// decoder state
	chd_pkg::phase_t phase_q, phase_d;
	logic              cr_seen_q, cr_seen_d;
	logic              in_ext_q, in_ext_d;
	logic [DIG_W-1:0]  digit_cnt_q, digit_cnt_d;
	chd_pkg::pend_t    pend_q, pend_d;
	logic [CNT_W-1:0]  size_acc_q, size_acc_d;
	logic [CNT_W-1:0]  data_left_q, data_left_d;
	logic [CNT_W-1:0]  bytes_out_q, bytes_out_d;

	// output register
	logic            out_valid_q;
	logic            out_bvalid_q;
	logic [7:0]      out_byte_q;
	logic            out_fin_q;
	chd_pkg::status_t out_status_q;

	logic adv;

	// size-line character step (a pending CR folded in first, then this byte)
	logic              ln_cr;
	logic              ln_ext;
	logic [DIG_W-1:0]  ln_cnt;
	chd_pkg::pend_t    ln_pend;
	logic [CNT_W-1:0]  ln_acc;
	logic [4:0]        hex_v;
	logic [CNT_W+3:0]  acc_next;

	// per-byte decisions
	logic             lf_close;
	logic             bad_cnt;
	logic             chunk_over;
	logic             rep;
	chd_pkg::status_t rep_st;
	logic             start_data;
	logic             emit;

	// result item
	logic             res_valid;
	logic             res_bvalid;
	logic [7:0]       res_byte;
	logic             res_fin;
	chd_pkg::status_t res_status;

	// ---------------------------------------------------------------- handshake
	// a byte leaves the input register when the output register is empty or
	// is being taken in this cycle
	assign adv        = s1_valid_q && (!out_valid_q || decoded.ready);
	assign body.ready = !s1_valid_q || adv;

	// ---------------------------------------------------------- size line step
	assign hex_v    = chd_pkg::hex_digit(s1_byte_s1);
	assign acc_next = {size_acc_q, 4'h0} + (CNT_W + 4)'(hex_v[3:0]);

	always_comb begin
		ln_cr   = cr_seen_q;
		ln_ext  = in_ext_q;
		ln_cnt  = digit_cnt_q;
		ln_pend = pend_q;
		ln_acc  = size_acc_q;
		// CR not followed by LF counts as an ordinary (bad) line character
		if (cr_seen_q) begin
			ln_cr = 1'b0;
			if (!ln_ext) begin
				if (ln_cnt != DIG_SAT) begin
					ln_cnt = ln_cnt + DIG_W'(1);
				end
				if (ln_pend == chd_pkg::PE_NONE) begin
					ln_pend = chd_pkg::PE_BAD_LENGTH;
				end
			end
		end
		if (s1_byte_s1 == chd_pkg::CH_CR) begin
			ln_cr = 1'b1;
		end else if (!ln_ext) begin
			if (s1_byte_s1 == chd_pkg::CH_SEMI) begin
				ln_ext = 1'b1;
			end else begin
				if (ln_cnt != DIG_SAT) begin
					ln_cnt = ln_cnt + DIG_W'(1);
				end
				// digits stop accumulating once an error is pending
				if (ln_pend == chd_pkg::PE_NONE) begin
					if (hex_v[4]) begin
						ln_pend = chd_pkg::PE_BAD_LENGTH;
					end else if (acc_next > MAX_NEXT) begin
						ln_pend = chd_pkg::PE_TOO_LARGE;
					end else begin
						ln_acc = acc_next[CNT_W-1:0];
					end
				end
			end
		end
	end

	// ----------------------------------------------------------------- decode
	assign lf_close   = cr_seen_q && (s1_byte_s1 == chd_pkg::CH_LF);
	assign bad_cnt    = (digit_cnt_q == '0) || (digit_cnt_q > DIG_LIM);
	// total output would pass the cap with this chunk
	assign chunk_over = ({1'b0, bytes_out_q} + {1'b0, size_acc_q}) > MAX_SUM;

	always_comb begin
		rep        = 1'b0;
		rep_st     = chd_pkg::ST_OK;
		start_data = 1'b0;
		emit       = 1'b0;
		unique case (phase_q)
			chd_pkg::PH_SIZE: begin
				if (lf_close) begin
					// length problems outrank pending errors
					if (bad_cnt) begin
						rep    = 1'b1;
						rep_st = chd_pkg::ST_BAD_LENGTH;
					end else if (pend_q != chd_pkg::PE_NONE) begin
						rep    = 1'b1;
						rep_st = chd_pkg::pend_status(pend_q);
					end else if (size_acc_q == '0) begin
						rep    = 1'b1;
						rep_st = chd_pkg::ST_OK;
					end else if (s1_last_s1 || chunk_over) begin
						rep    = 1'b1;
						rep_st = chd_pkg::ST_INCOMPLETE;
					end else begin
						start_data = 1'b1;
					end
				end else if (s1_last_s1) begin
					rep    = 1'b1;
					rep_st = chd_pkg::ST_NO_LINE_END;
				end
			end
			chd_pkg::PH_DATA: begin
				// the last byte is never passed out; only the outcome is
				if (s1_last_s1) begin
					rep    = 1'b1;
					rep_st = (data_left_q > CNT_W'(1)) ? chd_pkg::ST_INCOMPLETE
						: chd_pkg::ST_BAD_BOUNDARY;
				end else begin
					emit = 1'b1;
				end
			end
			chd_pkg::PH_BND_CR: begin
				if (s1_byte_s1 != chd_pkg::CH_CR || s1_last_s1) begin
					rep    = 1'b1;
					rep_st = chd_pkg::ST_BAD_BOUNDARY;
				end
			end
			chd_pkg::PH_BND_LF: begin
				if (s1_byte_s1 != chd_pkg::CH_LF) begin
					rep    = 1'b1;
					rep_st = chd_pkg::ST_BAD_BOUNDARY;
				end else if (s1_last_s1) begin
					rep    = 1'b1;
					rep_st = chd_pkg::ST_INCOMPLETE;
				end
			end
			default: begin
				// outcome already sent: swallow bytes
			end
		endcase
	end

	// ------------------------------------------------------------- next phase
	always_comb begin
		phase_d = phase_q;
		if (adv) begin
			if (s1_last_s1) begin
				phase_d = chd_pkg::PH_SIZE;
			end else if (rep) begin
				phase_d = chd_pkg::PH_DONE;
			end else begin
				unique case (phase_q)
					chd_pkg::PH_SIZE: begin
						if (start_data) begin
							phase_d = chd_pkg::PH_DATA;
						end
					end
					chd_pkg::PH_DATA: begin
						if (data_left_q <= CNT_W'(1)) begin
							phase_d = chd_pkg::PH_BND_CR;
						end
					end
					chd_pkg::PH_BND_CR: phase_d = chd_pkg::PH_BND_LF;
					chd_pkg::PH_BND_LF: phase_d = chd_pkg::PH_SIZE;
					default:            phase_d = phase_q;
				endcase
			end
		end
	end

	// ---------------------------------------------------------- result item
	always_comb begin
		res_valid  = emit || rep;
		res_bvalid = emit;
		res_byte   = emit ? s1_byte_s1 : 8'h00;
		res_fin    = rep;
		res_status = rep ? rep_st : chd_pkg::ST_OK;
	end

	// ------------------------------------------------------ counters and line
	always_comb begin
		cr_seen_d   = cr_seen_q;
		in_ext_d    = in_ext_q;
		digit_cnt_d = digit_cnt_q;
		pend_d      = pend_q;
		size_acc_d  = size_acc_q;
		data_left_d = data_left_q;
		bytes_out_d = bytes_out_q;
		if (adv) begin
			if (phase_q == chd_pkg::PH_SIZE && !lf_close) begin
				cr_seen_d   = ln_cr;
				in_ext_d    = ln_ext;
				digit_cnt_d = ln_cnt;
				pend_d      = ln_pend;
				size_acc_d  = ln_acc;
			end
			// a new size line starts after a chunk opens or a boundary closes
			if (start_data || (phase_q == chd_pkg::PH_BND_LF && !rep)) begin
				cr_seen_d   = 1'b0;
				in_ext_d    = 1'b0;
				digit_cnt_d = '0;
				pend_d      = chd_pkg::PE_NONE;
				size_acc_d  = '0;
			end
			if (start_data) begin
				data_left_d = size_acc_q;
			end
			if (emit) begin
				if (data_left_q != '0) begin
					data_left_d = data_left_q - CNT_W'(1);
				end
				if (bytes_out_q < MAX_CNT) begin
					bytes_out_d = bytes_out_q + CNT_W'(1);
				end
			end
			// last byte of a body re-arms everything
			if (s1_last_s1) begin
				cr_seen_d   = 1'b0;
				in_ext_d    = 1'b0;
				digit_cnt_d = '0;
				pend_d      = chd_pkg::PE_NONE;
				size_acc_d  = '0;
				data_left_d = '0;
				bytes_out_d = '0;
			end
		end
	end

	// -------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= chd_pkg::PH_SIZE;
			cr_seen_q   <= 1'b0;
			in_ext_q    <= 1'b0;
			digit_cnt_q <= '0;
			pend_q      <= chd_pkg::PE_NONE;
			size_acc_q  <= '0;
			data_left_q <= '0;
			bytes_out_q <= '0;
		end else begin
			if (body.ready) begin
				s1_valid_q <= body.valid;
			end
			if (adv && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (decoded.ready) begin
				out_valid_q <= 1'b0;
			end
			phase_q     <= phase_d;
			cr_seen_q   <= cr_seen_d;
			in_ext_q    <= in_ext_d;
			digit_cnt_q <= digit_cnt_d;
			pend_q      <= pend_d;
			size_acc_q  <= size_acc_d;
			data_left_q <= data_left_d;
			bytes_out_q <= bytes_out_d;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (body.ready && body.valid) begin
			s1_byte_s1 <= body.in_byte;
			s1_last_s1 <= body.end_of_body;
		end
		if (adv && res_valid) begin
			out_bvalid_q <= res_bvalid;
			out_byte_q   <= res_byte;
			out_fin_q    <= res_fin;
			out_status_q <= res_status;
		end
	end

	assign decoded.valid      = out_valid_q;
	assign decoded.byte_valid = out_bvalid_q;
	assign decoded.out_byte   = out_byte_q;
	assign decoded.finished   = out_fin_q;
	assign decoded.status     = out_status_q;

	// -------------------------------------------------------------- assertions
	`CHD_ASSERT_IMP(a_item_kind, decoded.valid, decoded.byte_valid != decoded.finished, "bad item kind")
	`CHD_ASSERT_IMP(a_data_nonzero, phase_q == chd_pkg::PH_DATA, data_left_q != '0, "data phase empty")
	`CHD_ASSERT(a_total_cap, bytes_out_q <= MAX_CNT, "output total above cap")
	`CHD_ASSERT_IMP(a_byte_status, decoded.valid && decoded.byte_valid, decoded.status == chd_pkg::ST_OK, "byte status")

endmodule
